// ----- sv/lgpm_pkg.sv -----
// Shared types and constants for the levels/gamma pixel map.
// Holds the rebuild state encoding, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none
package lgpm_pkg;

  typedef enum logic [3:0] {
    ST_SETUP,
    ST_TDIV,
    ST_NORM,
    ST_SQ,
    ST_LG,
    ST_QDIV,
    ST_XMUL,
    ST_TMUL,
    ST_KDIV,
    ST_Y,
    ST_MUL,
    ST_WRITE,
    ST_RUN
  } lgpm_state_t;

  localparam logic [2:0] REG_IN_LO  = 3'd0;
  localparam logic [2:0] REG_IN_HI  = 3'd1;
  localparam logic [2:0] REG_OUT_LO = 3'd2;
  localparam logic [2:0] REG_OUT_HI = 3'd3;
  localparam logic [2:0] REG_GAMMA  = 3'd4;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned GAMMA_W = 28;

  // one entry per 8-bit pixel value; v = index*257 assumes this size
  localparam int unsigned TABLE_ENTRIES = 256;

  localparam logic [15:0]        IN_LO_RST  = 16'd0;
  localparam logic [15:0]        IN_HI_RST  = 16'hffff;
  localparam logic [15:0]        OUT_LO_RST = 16'd0;
  localparam logic [15:0]        OUT_HI_RST = 16'hffff;
  localparam logic [GAMMA_W-1:0] GAMMA_RST  = 28'd16777216;
  localparam logic [GAMMA_W-1:0] GAMMA_MIN  = 28'd167772;
  localparam logic [GAMMA_W-1:0] GAMMA_MAX  = 28'd167772160;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [4:0]  SQ_LAST = 5'd23;
  localparam logic [4:0]  SERIES_TERMS = 5'd16;

  // shared divider: 53-bit dividend covers lg<<24, 28-bit divisor covers gamma
  localparam int unsigned DIV_DW = 53;
  localparam int unsigned DIV_VW = 28;

endpackage
`default_nettype wire

// ----- sv/lgpm_ifs.sv -----
// Valid/ready stream interfaces for input and output pixels.
// No dependencies.
`default_nettype none
interface lgpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface lgpm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface
`default_nettype wire

// ----- sv/levels_gamma_pixel_map_unit.sv -----
// Levels/gamma pixel map top level: config registers, table rebuild, pixel path.
// Depends on lgpm_pkg, lgpm_ifs, lgpm_ram and lgpm_div.
//
//  channel   dir   handshake        payload
//  pix_in    in    valid/ready      pixel_in  [7:0]
//  pix_out   out   valid/ready      pixel_out [7:0]
//  apb       in    psel/penable     paddr [4:0], pwdata/prdata [31:0]
//
// Once the table is built a pixel is taken every cycle while the output accepts results;
// its result passes through the table RAM read, then the output register with a skid stage.
// After reset and after each register write the table is rebuilt entry by entry,
// all 256 entries, using the shared divider for entries between the input levels;
// pix_in.ready stays low during the rebuild.
// A stalled output holds up to two results before pix_in.ready drops.
`default_nettype none
module levels_gamma_pixel_map_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  lgpm_in_if.sink                           pix_in,
  lgpm_out_if.source                        pix_out,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lgpm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  import lgpm_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  // configuration
  logic [15:0]        input_low;
  logic [15:0]        input_high;
  logic [15:0]        output_low;
  logic [15:0]        output_high;
  logic [GAMMA_W-1:0] gamma_value;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite
                   && (reg_idx == REG_IN_LO || reg_idx == REG_IN_HI
                       || reg_idx == REG_OUT_LO || reg_idx == REG_OUT_HI
                       || reg_idx == REG_GAMMA);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_low   <= IN_LO_RST;
      input_high  <= IN_HI_RST;
      output_low  <= OUT_LO_RST;
      output_high <= OUT_HI_RST;
      gamma_value <= GAMMA_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IN_LO:  input_low   <= pwdata[15:0];
        REG_IN_HI:  input_high  <= pwdata[15:0];
        REG_OUT_LO: output_low  <= pwdata[15:0];
        REG_OUT_HI: output_high <= pwdata[15:0];
        REG_GAMMA:  gamma_value <= pwdata[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IN_LO:  prdata = {16'd0, input_low};
      REG_IN_HI:  prdata = {16'd0, input_high};
      REG_OUT_LO: prdata = {16'd0, output_low};
      REG_OUT_HI: prdata = {16'd0, output_high};
      REG_GAMMA:  prdata = {4'd0, gamma_value};
      default:    prdata = '0;
    endcase
  end

  // rebuild sequencer
  lgpm_state_t state, state_next;

  logic [IW-1:0]        idx;
  logic [15:0]          v;
  logic [15:0]          hi_eff;
  logic [GAMMA_W-1:0]   g_sat;
  logic                 below, above, flat, mid;

  logic                 div_start;
  logic                 div_done;
  logic [DIV_DW-1:0]    div_num;
  logic [DIV_VW-1:0]    div_den;
  logic [DIV_DW-1:0]    div_quo;

  logic [16:0]          tq;
  logic [3:0]           p;
  logic [3:0]           p_scan;
  logic [4:0]           norm_sh;
  logic [30:0]          m_init;
  logic [30:0]          m;
  logic [61:0]          sq_prod;
  logic [31:0]          sq;
  logic [23:0]          frac;
  logic [4:0]           cnt;
  logic [28:0]          lg;
  logic                 q_over;
  logic [4:0]           qi;
  logic [23:0]          qf;
  logic [53:0]          xprod;
  logic [29:0]          x;
  logic [30:0]          term;
  logic [60:0]          tprod;
  logic [33:0]          pos;
  logic [33:0]          neg;
  logic [4:0]           k;
  logic [33:0]          e;
  logic [5:0]           s;
  logic [33:0]          rnd;
  logic [33:0]          ysh;
  logic [16:0]          y;
  logic signed [16:0]   dif;
  logic signed [34:0]   mulp;
  logic signed [35:0]   num;
  logic [7:0]           entry;
  logic                 ram_we;

  assign v      = 16'(idx) * 16'd257;
  assign hi_eff = (input_high < input_low) ? input_low : input_high;
  assign g_sat  = (gamma_value < GAMMA_MIN) ? GAMMA_MIN :
                  (gamma_value > GAMMA_MAX) ? GAMMA_MAX : gamma_value;
  assign below  = v < input_low;
  assign above  = v > hi_eff;
  assign flat   = hi_eff == input_low;
  assign mid    = !below && !above && !flat;

  assign tq = div_quo[16:0];

  always_comb begin
    p_scan = '0;
    for (int b = 1; b < 16; b++) begin
      if (tq[b]) begin
        p_scan = 4'(b);
      end
    end
  end

  assign norm_sh = 5'd30 - {1'b0, p_scan};
  assign m_init  = 31'({15'd0, tq[15:0]} << norm_sh);
  assign sq_prod = m * m;
  assign sq      = sq_prod[61:30];
  assign lg      = {5'd16 - {1'b0, p}, 24'd0} - {5'd0, frac};
  assign q_over  = div_quo[52:24] > 29'd16;
  assign xprod   = qf * LN2_Q30;
  assign tprod   = term * x;
  assign e       = pos - neg;
  assign s       = 6'd14 + {1'b0, qi};
  assign rnd     = e + (34'd1 << (s - 6'd1));
  assign ysh     = rnd >> s;
  assign dif     = $signed({1'b0, output_high}) - $signed({1'b0, output_low});
  assign mulp    = dif * $signed({1'b0, y});
  assign num     = $signed({4'd0, output_low, 16'd0}) + 36'(mulp) + 36'sd32768;

  // divider operands
  always_comb begin
    unique case (state)
      ST_SETUP: begin
        div_num = DIV_DW'({16'(v - input_low), 16'd0});
        div_den = DIV_VW'(hi_eff - input_low);
      end
      ST_LG: begin
        div_num = {lg, 24'd0};
        div_den = g_sat;
      end
      ST_TMUL: begin
        div_num = DIV_DW'(tprod[60:30]);
        div_den = DIV_VW'(k);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SETUP: state_next = mid ? ST_TDIV : ST_WRITE;
      ST_TDIV: begin
        if (div_done) begin
          state_next = (tq == 17'd0 || tq[16]) ? ST_MUL : ST_NORM;
        end
      end
      ST_NORM: state_next = ST_SQ;
      ST_SQ:   state_next = (cnt == SQ_LAST) ? ST_LG : ST_SQ;
      ST_LG:   state_next = ST_QDIV;
      ST_QDIV: begin
        if (div_done) begin
          state_next = q_over ? ST_MUL : ST_XMUL;
        end
      end
      ST_XMUL: state_next = ST_TMUL;
      ST_TMUL: state_next = ST_KDIV;
      ST_KDIV: begin
        if (div_done) begin
          state_next = (k == SERIES_TERMS) ? ST_Y : ST_TMUL;
        end
      end
      ST_Y:     state_next = ST_MUL;
      ST_MUL:   state_next = ST_WRITE;
      ST_WRITE: state_next = (idx == IW'(TABLE_ENTRIES - 1)) ? ST_RUN : ST_SETUP;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_SETUP;
    endcase
    // a register write restarts the rebuild
    if (cfg_wr) begin
      state_next = ST_SETUP;
    end
  end

  always_comb begin
    div_start = (state == ST_SETUP && mid) || state == ST_LG || state == ST_TMUL;
    ram_we    = state == ST_WRITE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SETUP;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        idx <= '0;
      end else if (state == ST_WRITE && state_next == ST_SETUP) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_SETUP: begin
        entry <= above ? output_high[15:8] : output_low[15:8];
      end
      ST_TDIV: begin
        y <= tq[16] ? 17'h10000 : 17'd0;
      end
      ST_NORM: begin
        p    <= p_scan;
        m    <= m_init;
        frac <= '0;
        cnt  <= '0;
      end
      ST_SQ: begin
        m    <= sq[31] ? sq[31:1] : sq[30:0];
        frac <= {frac[22:0], sq[31]};
        cnt  <= cnt + 1'b1;
      end
      ST_QDIV: begin
        qi <= div_quo[28:24];
        qf <= div_quo[23:0];
        y  <= '0;
      end
      ST_XMUL: begin
        x    <= xprod[53:24];
        term <= 31'h4000_0000;
        pos  <= 34'h4000_0000;
        neg  <= '0;
        k    <= 5'd1;
      end
      ST_KDIV: begin
        if (div_done) begin
          term <= div_quo[30:0];
          if (k[0]) begin
            neg <= neg + 34'(div_quo[30:0]);
          end else begin
            pos <= pos + 34'(div_quo[30:0]);
          end
          k <= k + 1'b1;
        end
      end
      ST_Y: begin
        y <= (ysh > 34'h10000) ? 17'h10000 : ysh[16:0];
      end
      ST_MUL: begin
        entry <= num[35] ? 8'd0 : num[31:24];
      end
      default: ;
    endcase
  end

  lgpm_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // pixel path
  logic [7:0] ram_q;
  logic       accept;
  logic       rd_v;
  logic       out_v;
  logic       sk_v;
  logic [7:0] out_d;
  logic [7:0] sk_d;
  logic       pop;
  logic [1:0] occ;

  lgpm_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (entry),
    .raddr (pix_in.pixel_in[IW-1:0]),
    .rdata (ram_q)
  );

  assign pop    = out_v && pix_out.ready;
  assign occ    = 2'(out_v) + 2'(sk_v) + 2'(rd_v);
  assign pix_in.ready = (state == ST_RUN) && ((occ - 2'(pop)) < 2'd2);
  assign accept = pix_in.valid && pix_in.ready;
  assign pix_out.valid     = out_v;
  assign pix_out.pixel_out = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else begin
      rd_v <= accept;
      if (!out_v || pop) begin
        if (sk_v) begin
          out_v <= 1'b1;
          sk_v  <= rd_v;
        end else begin
          out_v <= rd_v;
        end
      end else if (rd_v) begin
        sk_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || pop) begin
      if (sk_v) begin
        out_d <= sk_d;
        sk_d  <= ram_q;
      end else begin
        out_d <= ram_q;
      end
    end else if (rd_v) begin
      sk_d <= ram_q;
    end
  end

  a_ready_run: assert property (@(posedge clk) disable iff (rst)
    pix_in.ready |-> state == ST_RUN)
    else $error("input ready outside run state");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid holds data while output register is empty");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    $countones({out_v, sk_v, rd_v}) <= 2)
    else $error("pixel path over capacity");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> state == ST_SETUP && idx == '0)
    else $error("register write did not restart rebuild");

endmodule
`default_nettype wire

// ----- sv/lgpm_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module lgpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/lgpm_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the table rebuild.
// No dependencies.
`default_nettype none
module lgpm_div #(
  parameter int unsigned DW = 53,
  parameter int unsigned VW = 28
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] rem_next;
  logic [VW-1:0] den;
  logic [DW-1:0] quo;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh   = {rem, quo[DW-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_next = ge ? VW'(rem_sh - {1'b0, den}) : rem_sh[VW-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire
